// ----- design/spsm_pkg.sv -----
// Shared types, codes and field widths of the slotted page space manager.
`timescale 1ns / 1ps

package spsm_pkg;

    // Field widths of the request and result items.
    localparam int OP_W      = 2;
    localparam int SIZE_W    = 13;
    localparam int SLOTNUM_W = 10;
    localparam int FLAGS_W   = 8;
    localparam int STATUS_W  = 2;
    localparam int MARK_W    = 14;

    // Depth of the slot table; slot numbers are SLOTNUM_W bits wide.
    localparam int MAX_SLOTS = 512;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_SHUFFLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPECIAL = 1'd1;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_INIT   = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_IN_USE    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_SLOT  = 2'd3;

    // Datapath actions issued by the controller.
    localparam int ACT_W = 5;
    localparam logic [ACT_W-1:0] A_NONE       = 5'd0;
    localparam logic [ACT_W-1:0] A_ACCEPT     = 5'd1;
    localparam logic [ACT_W-1:0] A_INIT       = 5'd2;
    localparam logic [ACT_W-1:0] A_ADD_DECODE = 5'd3;
    localparam logic [ACT_W-1:0] A_RD_IDX     = 5'd4;
    localparam logic [ACT_W-1:0] A_CHK_TAKEN  = 5'd5;
    localparam logic [ACT_W-1:0] A_SCAN_RD    = 5'd6;
    localparam logic [ACT_W-1:0] A_FREE_EV    = 5'd7;
    localparam logic [ACT_W-1:0] A_ALIGN_ADD  = 5'd8;
    localparam logic [ACT_W-1:0] A_SPACE_CHK  = 5'd9;
    localparam logic [ACT_W-1:0] A_SHF_RD     = 5'd10;
    localparam logic [ACT_W-1:0] A_SHF_WR     = 5'd11;
    localparam logic [ACT_W-1:0] A_PLACE_NEW  = 5'd12;
    localparam logic [ACT_W-1:0] A_RM_CHK     = 5'd13;
    localparam logic [ACT_W-1:0] A_RM_CLR     = 5'd14;
    localparam logic [ACT_W-1:0] A_CLEAN_EV   = 5'd15;
    localparam logic [ACT_W-1:0] A_SEL_START  = 5'd16;
    localparam logic [ACT_W-1:0] A_SEL_EV     = 5'd17;
    localparam logic [ACT_W-1:0] A_ALIGN_BEST = 5'd18;
    localparam logic [ACT_W-1:0] A_PLACE_BEST = 5'd19;
    localparam logic [ACT_W-1:0] A_PTR_CLR    = 5'd20;
    localparam logic [ACT_W-1:0] A_COPY_EV    = 5'd21;
    localparam logic [ACT_W-1:0] A_FINISH_RM  = 5'd22;
    localparam logic [ACT_W-1:0] A_RESPOND    = 5'd23;

    // One request item.
    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [SIZE_W-1:0]    item_size;
        logic [SLOTNUM_W-1:0] slot_number;
        logic [FLAGS_W-1:0]   item_flags;
    } t_in_req;

    // One result item.
    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [SLOTNUM_W-1:0] slot_assigned;
        logic [MARK_W-1:0]    item_offset;
        logic [MARK_W-1:0]    free_bytes;
    } t_out_res;

    // One line pointer in the slot table.
    typedef struct packed {
        logic [MARK_W-1:0]  off;
        logic [MARK_W-1:0]  len;
        logic [FLAGS_W-1:0] flags;
    } t_entry;

    // Controller to datapath.
    typedef struct packed {
        logic [ACT_W-1:0] action;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            err;
        logic            need_chk;
        logic            free_scan;
        logic            ptr_done;
        logic            found;
        logic            shuf;
        logic            shf_done;
        logic            out_free;
    } t_stat;

endpackage

// ----- design/spsm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module spsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/spsm_ctrl.sv -----
// Controller state machine that sequences every request through the datapath.
`timescale 1ns / 1ps

module spsm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  spsm_pkg::t_stat i_stat,
    output spsm_pkg::t_cmd  o_cmd
);

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_DISPATCH  = 5'd1;
    localparam logic [4:0] S_ADD_BR    = 5'd2;
    localparam logic [4:0] S_TAKEN     = 5'd3;
    localparam logic [4:0] S_TAKEN_BR  = 5'd4;
    localparam logic [4:0] S_FREE_RD   = 5'd5;
    localparam logic [4:0] S_FREE_EV   = 5'd6;
    localparam logic [4:0] S_ALIGN     = 5'd7;
    localparam logic [4:0] S_SPACE     = 5'd8;
    localparam logic [4:0] S_SPACE_BR  = 5'd9;
    localparam logic [4:0] S_SHF_CHK   = 5'd10;
    localparam logic [4:0] S_SHF_WR    = 5'd11;
    localparam logic [4:0] S_PLACE     = 5'd12;
    localparam logic [4:0] S_RM_BR     = 5'd13;
    localparam logic [4:0] S_RM_CLR    = 5'd14;
    localparam logic [4:0] S_CLN_RD    = 5'd15;
    localparam logic [4:0] S_CLN_EV    = 5'd16;
    localparam logic [4:0] S_SEL_RD    = 5'd17;
    localparam logic [4:0] S_SEL_EV    = 5'd18;
    localparam logic [4:0] S_SEL_ALN   = 5'd19;
    localparam logic [4:0] S_SEL_PLACE = 5'd20;
    localparam logic [4:0] S_CPY_RD    = 5'd21;
    localparam logic [4:0] S_CPY_EV    = 5'd22;
    localparam logic [4:0] S_RESP      = 5'd23;

    logic [4:0]                   r_state;
    logic [4:0]                   n_state;
    logic [spsm_pkg::ACT_W-1:0]   w_action;

    // Next state and the action for the datapath in this cycle.
    always_comb begin
        n_state  = r_state;
        w_action = spsm_pkg::A_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_action = spsm_pkg::A_ACCEPT;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_stat.op)
                    spsm_pkg::OP_INIT: begin
                        w_action = spsm_pkg::A_INIT;
                        n_state  = S_RESP;
                    end
                    spsm_pkg::OP_ADD: begin
                        w_action = spsm_pkg::A_ADD_DECODE;
                        n_state  = S_ADD_BR;
                    end
                    spsm_pkg::OP_REMOVE: begin
                        w_action = spsm_pkg::A_RM_CHK;
                        n_state  = S_RM_BR;
                    end
                    default: begin
                        n_state = S_RESP;
                    end
                endcase
            end
            S_ADD_BR: begin
                if (i_stat.err) begin
                    n_state = S_RESP;
                end else if (i_stat.need_chk) begin
                    w_action = spsm_pkg::A_RD_IDX;
                    n_state  = S_TAKEN;
                end else if (i_stat.free_scan) begin
                    n_state = S_FREE_RD;
                end else begin
                    n_state = S_ALIGN;
                end
            end
            S_TAKEN: begin
                w_action = spsm_pkg::A_CHK_TAKEN;
                n_state  = S_TAKEN_BR;
            end
            S_TAKEN_BR: begin
                n_state = i_stat.err ? S_RESP : S_ALIGN;
            end
            S_FREE_RD: begin
                if (i_stat.found || i_stat.ptr_done) begin
                    n_state = S_ALIGN;
                end else begin
                    w_action = spsm_pkg::A_SCAN_RD;
                    n_state  = S_FREE_EV;
                end
            end
            S_FREE_EV: begin
                w_action = spsm_pkg::A_FREE_EV;
                n_state  = S_FREE_RD;
            end
            S_ALIGN: begin
                w_action = spsm_pkg::A_ALIGN_ADD;
                n_state  = S_SPACE;
            end
            S_SPACE: begin
                w_action = spsm_pkg::A_SPACE_CHK;
                n_state  = S_SPACE_BR;
            end
            S_SPACE_BR: begin
                if (i_stat.err) begin
                    n_state = S_RESP;
                end else if (i_stat.shuf) begin
                    n_state = S_SHF_CHK;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_SHF_CHK: begin
                if (i_stat.shf_done) begin
                    n_state = S_PLACE;
                end else begin
                    w_action = spsm_pkg::A_SHF_RD;
                    n_state  = S_SHF_WR;
                end
            end
            S_SHF_WR: begin
                w_action = spsm_pkg::A_SHF_WR;
                n_state  = S_SHF_CHK;
            end
            S_PLACE: begin
                w_action = spsm_pkg::A_PLACE_NEW;
                n_state  = S_RESP;
            end
            S_RM_BR: begin
                if (i_stat.err) begin
                    n_state = S_RESP;
                end else begin
                    w_action = spsm_pkg::A_RD_IDX;
                    n_state  = S_RM_CLR;
                end
            end
            S_RM_CLR: begin
                w_action = spsm_pkg::A_RM_CLR;
                n_state  = S_CLN_RD;
            end
            S_CLN_RD: begin
                if (i_stat.ptr_done) begin
                    w_action = spsm_pkg::A_SEL_START;
                    n_state  = S_SEL_RD;
                end else begin
                    w_action = spsm_pkg::A_SCAN_RD;
                    n_state  = S_CLN_EV;
                end
            end
            S_CLN_EV: begin
                w_action = spsm_pkg::A_CLEAN_EV;
                n_state  = S_CLN_RD;
            end
            S_SEL_RD: begin
                if (i_stat.ptr_done && i_stat.found) begin
                    n_state = S_SEL_ALN;
                end else if (i_stat.ptr_done) begin
                    w_action = spsm_pkg::A_PTR_CLR;
                    n_state  = S_CPY_RD;
                end else begin
                    w_action = spsm_pkg::A_SCAN_RD;
                    n_state  = S_SEL_EV;
                end
            end
            S_SEL_EV: begin
                w_action = spsm_pkg::A_SEL_EV;
                n_state  = S_SEL_RD;
            end
            S_SEL_ALN: begin
                w_action = spsm_pkg::A_ALIGN_BEST;
                n_state  = S_SEL_PLACE;
            end
            S_SEL_PLACE: begin
                w_action = spsm_pkg::A_PLACE_BEST;
                n_state  = S_SEL_RD;
            end
            S_CPY_RD: begin
                if (i_stat.ptr_done) begin
                    w_action = spsm_pkg::A_FINISH_RM;
                    n_state  = S_RESP;
                end else begin
                    w_action = spsm_pkg::A_SCAN_RD;
                    n_state  = S_CPY_EV;
                end
            end
            S_CPY_EV: begin
                w_action = spsm_pkg::A_COPY_EV;
                n_state  = S_CPY_RD;
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    w_action = spsm_pkg::A_RESPOND;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_cmd.action  = w_action;

endmodule

// ----- design/spsm_dp.sv -----
// Datapath: page marks, slot table, compaction scratch and the result register.
`timescale 1ns / 1ps

module spsm_dp #(
    parameter int PAGE_BYTES   = 8192,
    parameter int HEADER_BYTES = 12,
    parameter int SLOT_BYTES   = 4,
    parameter int ALIGN_BYTES  = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  spsm_pkg::t_cmd                      i_cmd,
    output spsm_pkg::t_stat                     o_stat,
    input  spsm_pkg::t_in_req                   i_in_req,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output spsm_pkg::t_out_res                  o_out_res,
    input  logic                                i_cfg_wr_en,
    input  logic [spsm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [spsm_pkg::CFG_DATA_W-1:0]     i_cfg_wr_data
);

    localparam int MAX_SLOTS  = spsm_pkg::MAX_SLOTS;
    localparam int BASE_LOWER = HEADER_BYTES - SLOT_BYTES;
    localparam int CNT_W      = $clog2(MAX_SLOTS + 1);
    localparam int IDX_W      = $clog2(MAX_SLOTS);
    localparam int MW         = spsm_pkg::MARK_W;
    localparam int SW         = MW + 2;
    localparam int CW         = 13;
    localparam int QW         = MW + 1;
    localparam int RECIP_SH   = 20;
    localparam int RECIP      = ((1 << RECIP_SH) + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam logic [RECIP_SH:0] RECIP_C = (RECIP_SH + 1)'(RECIP);
    localparam logic [3:0]        ALIGN_C = 4'(ALIGN_BYTES);
    localparam int EW         = $bits(spsm_pkg::t_entry);

    // Configuration and page state.
    logic                            r_shuffle, n_shuffle;
    logic [spsm_pkg::CFG_DATA_W-1:0] r_special, n_special;
    logic [MW-1:0]                   r_lower, n_lower;
    logic [MW-1:0]                   r_upper, n_upper;
    logic [MW-1:0]                   r_spec_start, n_spec_start;
    logic [CNT_W-1:0]                r_count, n_count;

    // Per-request working registers.
    spsm_pkg::t_in_req               r_req, n_req;
    logic [spsm_pkg::STATUS_W-1:0]   r_status, n_status;
    logic [spsm_pkg::SLOTNUM_W-1:0]  r_assigned, n_assigned;
    logic [MW-1:0]                   r_offset, n_offset;
    logic [CNT_W-1:0]                r_idx, n_idx;
    logic                            r_grows, n_grows;
    logic                            r_shuf, n_shuf;
    logic                            r_need_chk, n_need_chk;
    logic [CNT_W-1:0]                r_ptr, n_ptr;
    logic                            r_found, n_found;
    logic [MW-1:0]                   r_nu, n_nu;
    logic [MW-1:0]                   r_nl, n_nl;
    logic [QW-1:0]                   r_quot, n_quot;
    logic [MW-1:0]                   r_up, n_up;
    logic                            r_have_prev, n_have_prev;
    logic [MW-1:0]                   r_prev_off, n_prev_off;
    logic [CNT_W-1:0]                r_prev_idx, n_prev_idx;
    logic [MW-1:0]                   r_best_off, n_best_off;
    logic [CNT_W-1:0]                r_best_idx, n_best_idx;
    logic [MW-1:0]                   r_best_len, n_best_len;
    logic                            r_out_valid, n_out_valid;
    spsm_pkg::t_out_res              r_out_res, n_out_res;

    // Memory ports.
    spsm_pkg::t_entry                w_rd;
    logic [EW-1:0]                   w_rd_bits;
    logic                            w_tbl_we;
    logic [IDX_W-1:0]                w_tbl_waddr;
    spsm_pkg::t_entry                w_tbl_wdata;
    logic [IDX_W-1:0]                w_tbl_raddr;
    logic                            w_scr_we;
    logic [IDX_W-1:0]                w_scr_waddr;
    logic [MW-1:0]                   w_scr_wdata;
    logic [MW-1:0]                   w_scr_rd;

    // Arithmetic helpers.
    logic [IDX_W-1:0]                w_ptr_a;
    logic [CNT_W-1:0]                w_ptr_m1;
    logic [MW-1:0]                   w_al_src;
    logic [QW-1:0]                   w_al_x;
    logic [QW+RECIP_SH:0]            w_prod;
    logic [QW+3:0]                   w_al_full;
    logic [SW-1:0]                   w_al;
    logic [SW-1:0]                   w_nl;
    logic [SW-1:0]                   w_nu;
    logic                            w_space_bad;
    logic [SW-1:0]                   w_free_raw;
    logic [MW-1:0]                   w_free;
    logic [CW-1:0]                   w_slot;
    logic [CW-1:0]                   w_n;
    logic [CW-1:0]                   w_slot_m1;
    logic [SW-1:0]                   w_sp;
    logic [SW-1:0]                   w_start;
    logic [SW-1:0]                   w_up_sub;
    logic [MW-1:0]                   w_up_new;
    logic                            w_cand;
    logic                            w_better;

    assign w_rd     = spsm_pkg::t_entry'(w_rd_bits);
    assign w_ptr_a  = r_ptr[IDX_W-1:0];
    assign w_ptr_m1 = r_ptr - CNT_W'(1);

    // Word alignment: ceiling to a multiple of the alignment by a reciprocal multiply.
    assign w_al_src  = (i_cmd.action == spsm_pkg::A_ALIGN_BEST) ? r_best_len
                                                                : MW'(r_req.item_size);
    assign w_al_x    = {1'b0, w_al_src} + QW'(ALIGN_BYTES - 1);
    assign w_prod    = w_al_x * RECIP_C;
    assign w_al_full = r_quot * ALIGN_C;
    assign w_al      = w_al_full[SW-1:0];

    // Space check for an add.
    assign w_nl = {2'b00, r_lower} + (r_grows ? SW'(SLOT_BYTES) : SW'(0));
    assign w_nu = {2'b00, r_upper} - w_al;
    assign w_space_bad = (r_grows && ({1'b0, r_count} >= (CNT_W + 1)'(MAX_SLOTS)))
                         || ($signed(w_nl) > $signed(w_nu));

    // Free gap, saturated at zero.
    assign w_free_raw = {2'b00, r_upper} - {2'b00, r_lower} - SW'(SLOT_BYTES);
    assign w_free     = w_free_raw[SW-1] ? '0 : w_free_raw[MW-1:0];

    // Slot number compares.
    assign w_slot    = CW'(r_req.slot_number);
    assign w_n       = CW'(r_count);
    assign w_slot_m1 = w_slot - CW'(1);

    // Special area start at init, with the area clamped to the page.
    assign w_sp    = (SW'(r_special) > SW'(PAGE_BYTES - BASE_LOWER))
                     ? SW'(PAGE_BYTES - BASE_LOWER) : SW'(r_special);
    assign w_start = SW'(PAGE_BYTES) - w_sp;

    // Compaction cursor moves down by one aligned item, floored at zero.
    assign w_up_sub = {2'b00, r_up} - w_al;
    assign w_up_new = w_up_sub[SW-1] ? '0 : w_up_sub[MW-1:0];

    // Next item in descending-offset order: below the last placed one in that order.
    assign w_cand   = w_rd.flags[0]
                      && (!r_have_prev || (w_rd.off < r_prev_off)
                          || ((w_rd.off == r_prev_off) && (r_ptr > r_prev_idx)));
    assign w_better = !r_found || (w_rd.off > r_best_off);

    // Memory address and write selection.
    always_comb begin
        w_tbl_we    = 1'b0;
        w_tbl_waddr = w_ptr_a;
        w_tbl_wdata = w_rd;
        w_tbl_raddr = w_ptr_a;
        w_scr_we    = 1'b0;
        w_scr_waddr = r_best_idx[IDX_W-1:0];
        w_scr_wdata = w_up_new;
        case (i_cmd.action)
            spsm_pkg::A_RD_IDX: begin
                w_tbl_raddr = r_idx[IDX_W-1:0];
            end
            spsm_pkg::A_SHF_RD: begin
                w_tbl_raddr = w_ptr_m1[IDX_W-1:0];
            end
            spsm_pkg::A_SHF_WR: begin
                w_tbl_we = 1'b1;
            end
            spsm_pkg::A_PLACE_NEW: begin
                w_tbl_we          = 1'b1;
                w_tbl_waddr       = r_idx[IDX_W-1:0];
                w_tbl_wdata.off   = r_nu;
                w_tbl_wdata.len   = MW'(r_req.item_size);
                w_tbl_wdata.flags = r_req.item_flags;
            end
            spsm_pkg::A_RM_CLR: begin
                w_tbl_we             = 1'b1;
                w_tbl_waddr          = r_idx[IDX_W-1:0];
                w_tbl_wdata.flags[0] = 1'b0;
            end
            spsm_pkg::A_CLEAN_EV: begin
                w_tbl_we        = !w_rd.flags[0] && (w_rd.len != '0);
                w_tbl_wdata.len = '0;
            end
            spsm_pkg::A_PLACE_BEST: begin
                w_scr_we = 1'b1;
            end
            spsm_pkg::A_COPY_EV: begin
                w_tbl_we        = w_rd.flags[0];
                w_tbl_wdata.off = w_scr_rd;
            end
            default: begin
            end
        endcase
    end

    // Next values of all registers.
    always_comb begin
        n_shuffle    = r_shuffle;
        n_special    = r_special;
        n_lower      = r_lower;
        n_upper      = r_upper;
        n_spec_start = r_spec_start;
        n_count      = r_count;
        n_req        = r_req;
        n_status     = r_status;
        n_assigned   = r_assigned;
        n_offset     = r_offset;
        n_idx        = r_idx;
        n_grows      = r_grows;
        n_shuf       = r_shuf;
        n_need_chk   = r_need_chk;
        n_ptr        = r_ptr;
        n_found      = r_found;
        n_nu         = r_nu;
        n_nl         = r_nl;
        n_quot       = r_quot;
        n_up         = r_up;
        n_have_prev  = r_have_prev;
        n_prev_off   = r_prev_off;
        n_prev_idx   = r_prev_idx;
        n_best_off   = r_best_off;
        n_best_idx   = r_best_idx;
        n_best_len   = r_best_len;
        n_out_res    = r_out_res;
        n_out_valid  = r_out_valid && i_out_stall;

        // Configuration writes.
        if (i_cfg_wr_en) begin
            case (i_cfg_index)
                spsm_pkg::CFG_SHUFFLE: n_shuffle = i_cfg_wr_data[0];
                spsm_pkg::CFG_SPECIAL: n_special = i_cfg_wr_data;
                default: begin
                end
            endcase
        end

        case (i_cmd.action)
            spsm_pkg::A_ACCEPT: begin
                n_req      = i_in_req;
                n_status   = spsm_pkg::ST_OK;
                n_assigned = '0;
                n_offset   = '0;
            end
            spsm_pkg::A_INIT: begin
                n_lower      = MW'(BASE_LOWER);
                n_count      = '0;
                n_spec_start = w_start[MW-1:0];
                n_upper      = w_start[MW-1:0];
            end
            spsm_pkg::A_ADD_DECODE: begin
                n_idx      = r_count;
                n_grows    = 1'b1;
                n_shuf     = 1'b0;
                n_need_chk = 1'b0;
                n_ptr      = '0;
                n_found    = 1'b0;
                if (w_slot != '0) begin
                    if ((w_slot > w_n + CW'(1)) || (w_slot > CW'(MAX_SLOTS))) begin
                        n_status = spsm_pkg::ST_BAD_SLOT;
                    end else if (r_shuffle) begin
                        n_idx  = w_slot_m1[CNT_W-1:0];
                        n_shuf = 1'b1;
                    end else if (w_slot <= w_n) begin
                        n_idx      = w_slot_m1[CNT_W-1:0];
                        n_grows    = 1'b0;
                        n_need_chk = 1'b1;
                    end
                end
            end
            spsm_pkg::A_CHK_TAKEN: begin
                if (w_rd.flags[0] || (w_rd.len != '0)) begin
                    n_status = spsm_pkg::ST_IN_USE;
                end
            end
            spsm_pkg::A_FREE_EV: begin
                if (!w_rd.flags[0] && (w_rd.len == '0)) begin
                    n_idx   = r_ptr;
                    n_grows = 1'b0;
                    n_found = 1'b1;
                end
                n_ptr = r_ptr + CNT_W'(1);
            end
            spsm_pkg::A_ALIGN_ADD, spsm_pkg::A_ALIGN_BEST: begin
                n_quot = w_prod[RECIP_SH +: QW];
            end
            spsm_pkg::A_SPACE_CHK: begin
                n_nl  = w_nl[MW-1:0];
                n_nu  = w_nu[MW-1:0];
                n_ptr = r_count;
                if (w_space_bad) begin
                    n_status = spsm_pkg::ST_NO_SPACE;
                end
            end
            spsm_pkg::A_SHF_WR: begin
                n_ptr = w_ptr_m1;
            end
            spsm_pkg::A_PLACE_NEW: begin
                n_lower    = r_nl;
                n_upper    = r_nu;
                n_count    = r_count + (r_grows ? CNT_W'(1) : CNT_W'(0));
                n_assigned = spsm_pkg::SLOTNUM_W'(r_idx + CNT_W'(1));
                n_offset   = r_nu;
            end
            spsm_pkg::A_RM_CHK: begin
                n_idx = w_slot_m1[CNT_W-1:0];
                if ((w_slot == '0) || (w_slot > w_n)) begin
                    n_status = spsm_pkg::ST_BAD_SLOT;
                end
            end
            spsm_pkg::A_RM_CLR: begin
                n_ptr = '0;
            end
            spsm_pkg::A_CLEAN_EV, spsm_pkg::A_COPY_EV: begin
                n_ptr = r_ptr + CNT_W'(1);
            end
            spsm_pkg::A_SEL_START: begin
                n_up        = r_spec_start;
                n_have_prev = 1'b0;
                n_ptr       = '0;
                n_found     = 1'b0;
            end
            spsm_pkg::A_SEL_EV: begin
                if (w_cand && w_better) begin
                    n_best_off = w_rd.off;
                    n_best_idx = r_ptr;
                    n_best_len = w_rd.len;
                    n_found    = 1'b1;
                end
                n_ptr = r_ptr + CNT_W'(1);
            end
            spsm_pkg::A_PLACE_BEST: begin
                n_up        = w_up_new;
                n_prev_off  = r_best_off;
                n_prev_idx  = r_best_idx;
                n_have_prev = 1'b1;
                n_ptr       = '0;
                n_found     = 1'b0;
            end
            spsm_pkg::A_PTR_CLR: begin
                n_ptr   = '0;
                n_found = 1'b0;
            end
            spsm_pkg::A_FINISH_RM: begin
                n_upper = r_up;
            end
            spsm_pkg::A_RESPOND: begin
                n_out_valid             = 1'b1;
                n_out_res.status        = r_status;
                n_out_res.slot_assigned = r_assigned;
                n_out_res.item_offset   = r_offset;
                n_out_res.free_bytes    = w_free;
            end
            default: begin
            end
        endcase
    end

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shuffle    <= 1'b1;
            r_special    <= '0;
            r_lower      <= MW'(BASE_LOWER);
            r_upper      <= MW'(PAGE_BYTES);
            r_spec_start <= MW'(PAGE_BYTES);
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_shuffle    <= n_shuffle;
            r_special    <= n_special;
            r_lower      <= n_lower;
            r_upper      <= n_upper;
            r_spec_start <= n_spec_start;
            r_count      <= n_count;
            r_out_valid  <= n_out_valid;
        end
    end

    // Working registers; each is written before it is used in a request.
    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_status    <= n_status;
        r_assigned  <= n_assigned;
        r_offset    <= n_offset;
        r_idx       <= n_idx;
        r_grows     <= n_grows;
        r_shuf      <= n_shuf;
        r_need_chk  <= n_need_chk;
        r_ptr       <= n_ptr;
        r_found     <= n_found;
        r_nu        <= n_nu;
        r_nl        <= n_nl;
        r_quot      <= n_quot;
        r_up        <= n_up;
        r_have_prev <= n_have_prev;
        r_prev_off  <= n_prev_off;
        r_prev_idx  <= n_prev_idx;
        r_best_off  <= n_best_off;
        r_best_idx  <= n_best_idx;
        r_best_len  <= n_best_len;
        r_out_res   <= n_out_res;
    end

    // Slot table: offset, length and flags of each line pointer.
    spsm_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_tbl_we),
        .i_waddr (w_tbl_waddr),
        .i_wdata (w_tbl_wdata),
        .i_raddr (w_tbl_raddr),
        .o_rdata (w_rd_bits)
    );

    // Scratch store of new offsets computed during compaction.
    spsm_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_SLOTS)
    ) u_scratch (
        .i_clk   (i_clk),
        .i_we    (w_scr_we),
        .i_waddr (w_scr_waddr),
        .i_wdata (w_scr_wdata),
        .i_raddr (w_ptr_a),
        .o_rdata (w_scr_rd)
    );

    // Status back to the controller.
    assign o_stat.op        = r_req.op;
    assign o_stat.err       = (r_status != spsm_pkg::ST_OK);
    assign o_stat.need_chk  = r_need_chk;
    assign o_stat.free_scan = (r_req.slot_number == '0);
    assign o_stat.ptr_done  = (r_ptr >= r_count);
    assign o_stat.found     = r_found;
    assign o_stat.shuf      = r_shuf;
    assign o_stat.shf_done  = (r_ptr <= r_idx);
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

`ifndef ASSERT_OFF
    // The lower mark always sits one slot width short of the end of the slot table.
    a_lower_tracks_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {2'b00, r_lower} == SW'(BASE_LOWER) + SW'(r_count) * SW'(SLOT_BYTES))
        else $error("lower mark does not match slot count");

    // Items never reach into the special area.
    a_upper_below_special: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_upper <= r_spec_start)
        else $error("upper mark above special area start");

    // The slot table never grows past its depth.
    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_count} <= (CNT_W + 1)'(MAX_SLOTS))
        else $error("slot count beyond table depth");

    // A failed request reports no slot and no offset.
    a_fail_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.action == spsm_pkg::A_RESPOND && r_status != spsm_pkg::ST_OK)
        |=> (o_out_res.slot_assigned == '0 && o_out_res.item_offset == '0))
        else $error("failed request reports a slot");
`endif

endmodule

// ----- design/slotted_page_space_manager_top.sv -----
// Top level of the slotted page space manager: controller, datapath and ports.
`timescale 1ns / 1ps

// Keeps the line-pointer table and free gap of one page. Each request gives
// exactly one result; a new request is taken only after the previous one has
// finished, while its result may still wait in the output register. An add
// visits slots one by one in the free-slot search or moves them one by one
// in the shuffle, and first checks a given slot for overwrite when it does
// not grow the table. The time of a remove is set by the single read port of
// the slot table: the compaction walks the whole table once for every used
// item to pick the next one in descending-offset order. The table depth is
// fixed by the package. No clearing pass follows reset.
module slotted_page_space_manager_top #(
    parameter int PAGE_BYTES   = 8192,
    parameter int HEADER_BYTES = 12,
    parameter int SLOT_BYTES   = 4,
    parameter int ALIGN_BYTES  = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  spsm_pkg::t_in_req                   i_in_req,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output spsm_pkg::t_out_res                  o_out_res,
    input  logic                                i_cfg_wr_en,
    input  logic [spsm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [spsm_pkg::CFG_DATA_W-1:0]     i_cfg_wr_data
);

    spsm_pkg::t_cmd  w_cmd;
    spsm_pkg::t_stat w_stat;

    // Sequencer.
    spsm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Marks, slot table and result register.
    spsm_dp #(
        .PAGE_BYTES   (PAGE_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .SLOT_BYTES   (SLOT_BYTES),
        .ALIGN_BYTES  (ALIGN_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_in_req      (i_in_req),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_res     (o_out_res),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

endmodule
